>>> rtl/dpfd_pkg.sv
// ----------------------------------------------------------------------------
// dpfd_pkg
// Shared widths, register indexes and unit status type for the PID block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dpfd_pkg;

  // Field and datapath widths fixed by the interface
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int QUO_W     = 63;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_N = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MAX = 3'd6;

  // Status of a bit-serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

>>> rtl/dpfd_mul.sv
// ----------------------------------------------------------------------------
// dpfd_mul
// Bit-serial signed multiplier: one multiplier bit per cycle, exact product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpfd_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [dpfd_pkg::DATA_W-1:0]  op_a_i,
  input  logic signed [dpfd_pkg::DATA_W-1:0]  op_b_i,
  output logic signed [dpfd_pkg::PROD_W-1:0]  prod_o,
  output dpfd_pkg::unit_sts_t                 sts_o
);

  localparam int W     = dpfd_pkg::DATA_W;
  localparam int CNT_W = $clog2(W);

  logic             run_q;
  logic             fin_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic             neg_q;
  logic [W-1:0]     a_q;
  logic [W-1:0]     b_q;
  logic [W-1:0]     hi_q;
  logic [2*W-1:0]   prod_q;

  logic [W-1:0]     a_bits;
  logic [W-1:0]     b_bits;
  logic [W-1:0]     mag_a;
  logic [W-1:0]     mag_b;
  logic [W:0]       sum;
  logic [2*W-1:0]   raw;

  always_comb begin
    a_bits = op_a_i;
    b_bits = op_b_i;
    mag_a  = a_bits[W-1] ? (~a_bits + W'(1)) : a_bits;
    mag_b  = b_bits[W-1] ? (~b_bits + W'(1)) : b_bits;
    sum    = {1'b0, hi_q} + (b_q[0] ? {1'b0, a_q} : {(W+1){1'b0}});
    raw    = {hi_q, b_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(W - 1)) begin
          run_q <= 1'b0;
          fin_q <= 1'b1;
        end
      end
    end
  end

  // Shift-add on magnitudes; the product grows into hi_q and shifts into b_q
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= mag_a;
      b_q   <= mag_b;
      hi_q  <= '0;
      neg_q <= a_bits[W-1] ^ b_bits[W-1];
    end else if (run_q) begin
      hi_q <= sum[W:1];
      b_q  <= {sum[0], b_q[W-1:1]};
    end
    if (fin_q) begin
      prod_q <= neg_q ? (~raw + (2*W)'(1)) : raw;
    end
  end

  assign prod_o     = prod_q;
  assign sts_o.busy = run_q | fin_q;
  assign sts_o.done = done_q;

endmodule

>>> rtl/dpfd_div.sv
// ----------------------------------------------------------------------------
// dpfd_div
// Restoring unsigned divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpfd_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [dpfd_pkg::QUO_W-1:0]         dividend_i,
  input  logic [dpfd_pkg::DATA_W-1:0]        divisor_i,
  output logic [dpfd_pkg::QUO_W-1:0]         quotient_o,
  output dpfd_pkg::unit_sts_t                sts_o
);

  localparam int W     = dpfd_pkg::DATA_W;
  localparam int Q     = dpfd_pkg::QUO_W;
  localparam int CNT_W = $clog2(Q);

  logic             run_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [Q-1:0]     dq_q;
  logic [W-1:0]     rem_q;
  logic [W-1:0]     dvs_q;

  logic [W:0]       rem_sh;
  logic             ge;
  logic [W:0]       rem_nx;

  always_comb begin
    rem_sh = {rem_q, dq_q[Q-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    rem_nx = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(Q - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Dividend bits leave at the top while quotient bits enter at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      dq_q  <= {dq_q[Q-2:0], ge};
      rem_q <= rem_nx[W-1:0];
    end
  end

  assign quotient_o = dq_q;
  assign sts_o.busy = run_q;
  assign sts_o.done = done_q;

endmodule

>>> rtl/discrete_pid_filtered_derivative.sv
// ----------------------------------------------------------------------------
// discrete_pid_filtered_derivative
// Each item takes ten products on the shared bit-serial multiplier and one
// 63-step restoring division; a new item is accepted only once the last
// result has been pushed out.
// Reset zeroes the gains, filter constant and histories, sets the period to
// 1.0 and opens the drive clamps to the full signed range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module discrete_pid_filtered_derivative #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [dpfd_pkg::DATA_W-1:0]   setpoint_i,
  input  logic signed [dpfd_pkg::DATA_W-1:0]   measured_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [dpfd_pkg::DATA_W-1:0]   drive_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [dpfd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [dpfd_pkg::DATA_W-1:0]          cfg_data_i
);

  localparam int W     = dpfd_pkg::DATA_W;
  localparam int Q     = dpfd_pkg::QUO_W;
  localparam int ACC_W = 67 - FRAC_BITS;

  localparam logic signed [63:0] ONE_64  = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] TWO_64  = 64'sd2 <<< FRAC_BITS;
  localparam logic signed [63:0] LIM_64  = 64'sd1 <<< (62 - FRAC_BITS);
  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;
  localparam logic signed [W-1:0] MAX32  = 32'sh7fffffff;
  localparam logic signed [W-1:0] MIN32  = 32'sh80000000;
  localparam logic [30:0]        TA_RESET = 31'd1 << FRAC_BITS;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_MUL_GO   = 3'd1;
  localparam logic [2:0] ST_MUL_WAIT = 3'd2;
  localparam logic [2:0] ST_DIV_GO   = 3'd3;
  localparam logic [2:0] ST_DIV_WAIT = 3'd4;
  localparam logic [2:0] ST_PUSH     = 3'd5;

  localparam logic [3:0] STEP_NT   = 4'd0;
  localparam logic [3:0] STEP_KDN  = 4'd1;
  localparam logic [3:0] STEP_KITA = 4'd2;
  localparam logic [3:0] STEP_P1   = 4'd3;
  localparam logic [3:0] STEP_P2   = 4'd4;
  localparam logic [3:0] STEP_P3   = 4'd5;
  localparam logic [3:0] STEP_U1   = 4'd6;
  localparam logic [3:0] STEP_E0   = 4'd7;
  localparam logic [3:0] STEP_E1   = 4'd8;
  localparam logic [3:0] STEP_E2   = 4'd9;

  function automatic logic signed [63:0] sx64(input logic signed [W-1:0] v);
    return {{32{v[W-1]}}, v};
  endfunction

  function automatic logic signed [W-1:0] sat32(input logic signed [63:0] x);
    logic signed [W-1:0] r;
    if (x > S32_MAX) begin
      r = MAX32;
    end else if (x < S32_MIN) begin
      r = MIN32;
    end else begin
      r = x[W-1:0];
    end
    return r;
  endfunction

  // Configuration and history
  logic signed [W-1:0] kp_q, kd_q, ki_q, umin_q, umax_q;
  logic [30:0]         n_q, ta_q;
  logic signed [W-1:0] e1_q, e2_q, u1_q, u2_q;

  // Per-item working registers
  logic signed [W-1:0]     e0_q;
  logic signed [W-1:0]     nt_q, kdn_q, kita_q, p1_q, p2_q, p3_q;
  logic signed [ACC_W-1:0] acc_q;
  logic                    neg_q;
  logic signed [W-1:0]     u_q;
  logic [2:0]              state_q, state_d;
  logic [3:0]              step_q;
  logic                    out_valid_q;
  logic signed [W-1:0]     drive_q;

  logic                    accept;
  logic                    push;
  logic                    mul_start, div_start;
  dpfd_pkg::unit_sts_t     mul_sts, div_sts;
  logic signed [63:0]      mul_prod;
  logic signed [63:0]      prod_sh;
  logic [Q-1:0]            div_quo;

  logic signed [63:0]      nt64;
  logic signed [W-1:0]     one_nt, two_nt, ca, kdn2, cb_pos, cb, cc;
  logic signed [W-1:0]     op_a, op_b;
  logic signed [63:0]      acc64, sum_sat, sum_mag;
  logic                    sum_neg;
  logic [Q-1:0]            dividend;
  logic                    q_big_neg, q_big_pos;
  logic signed [W-1:0]     u_raw, u_clamp;

  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign push        = (state_q == ST_PUSH) && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

  // Coefficients from the stored products
  always_comb begin
    nt64   = sx64(nt_q);
    one_nt = sat32(ONE_64 + nt64);
    two_nt = sat32(TWO_64 + nt64);
    ca     = sat32(sx64(p1_q) + sx64(p2_q) + sx64(kdn_q));
    kdn2   = sat32(sx64(kdn_q) <<< 1);
    cb_pos = sat32(sx64(p3_q) + sx64(kita_q) + sx64(kdn2));
    cb     = sat32(-sx64(cb_pos));
    cc     = sat32(sx64(kp_q) + sx64(kdn_q));
  end

  always_comb begin
    case (step_q)
      STEP_NT: begin
        op_a = $signed({1'b0, n_q});
        op_b = $signed({1'b0, ta_q});
      end
      STEP_KDN: begin
        op_a = kd_q;
        op_b = $signed({1'b0, n_q});
      end
      STEP_KITA: begin
        op_a = ki_q;
        op_b = $signed({1'b0, ta_q});
      end
      STEP_P1: begin
        op_a = kp_q;
        op_b = one_nt;
      end
      STEP_P2: begin
        op_a = kita_q;
        op_b = one_nt;
      end
      STEP_P3: begin
        op_a = kp_q;
        op_b = two_nt;
      end
      STEP_U1: begin
        op_a = two_nt;
        op_b = u1_q;
      end
      STEP_E0: begin
        op_a = ca;
        op_b = e0_q;
      end
      STEP_E1: begin
        op_a = cb;
        op_b = e1_q;
      end
      STEP_E2: begin
        op_a = cc;
        op_b = e2_q;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Numerator saturation and dividend; quotient saturation and drive clamp
  always_comb begin
    prod_sh = mul_prod >>> FRAC_BITS;
    acc64   = {{(64 - ACC_W){acc_q[ACC_W-1]}}, acc_q};
    if (acc64 > LIM_64) begin
      sum_sat = LIM_64;
    end else if (acc64 < -LIM_64) begin
      sum_sat = -LIM_64;
    end else begin
      sum_sat = acc64;
    end
    sum_neg  = sum_sat[63];
    sum_mag  = sum_neg ? -sum_sat : sum_sat;
    dividend = sum_mag[Q-1:0] << FRAC_BITS;

    q_big_neg = (|div_quo[Q-1:W]) || (div_quo[W-1] && (|div_quo[W-2:0]));
    q_big_pos = |div_quo[Q-1:W-1];
    if (neg_q) begin
      u_raw = q_big_neg ? MIN32 : $signed(~div_quo[W-1:0] + W'(1));
    end else begin
      u_raw = q_big_pos ? MAX32 : $signed(div_quo[W-1:0]);
    end
    u_clamp = u_raw;
    if (u_clamp > umax_q) begin
      u_clamp = umax_q;
    end
    if (u_clamp <= umin_q) begin
      u_clamp = umin_q;
    end
  end

  always_comb begin
    state_d   = state_q;
    mul_start = 1'b0;
    div_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_MUL_GO;
        end
      end
      ST_MUL_GO: begin
        if (!mul_sts.busy) begin
          mul_start = 1'b1;
          state_d   = ST_MUL_WAIT;
        end
      end
      ST_MUL_WAIT: begin
        if (mul_sts.done) begin
          state_d = (step_q == STEP_E2) ? ST_DIV_GO : ST_MUL_GO;
        end
      end
      ST_DIV_GO: begin
        if (!div_sts.busy) begin
          div_start = 1'b1;
          state_d   = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (div_sts.done) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (push) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_NT;
      out_valid_q <= 1'b0;
      kp_q        <= '0;
      kd_q        <= '0;
      ki_q        <= '0;
      n_q         <= '0;
      ta_q        <= TA_RESET;
      umin_q      <= MIN32;
      umax_q      <= MAX32;
      e1_q        <= '0;
      e2_q        <= '0;
      u1_q        <= '0;
      u2_q        <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        step_q <= STEP_NT;
      end else if ((state_q == ST_MUL_WAIT) && mul_sts.done) begin
        step_q <= step_q + 4'd1;
      end

      if (push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_valid_i) begin
        case (cfg_index_i)
          dpfd_pkg::REG_GAIN_P:    kp_q   <= cfg_data_i;
          dpfd_pkg::REG_GAIN_D:    kd_q   <= cfg_data_i;
          dpfd_pkg::REG_GAIN_I:    ki_q   <= cfg_data_i;
          dpfd_pkg::REG_FILTER_N:  n_q    <= cfg_data_i[30:0];
          dpfd_pkg::REG_PERIOD:    ta_q   <= cfg_data_i[30:0];
          dpfd_pkg::REG_DRIVE_MIN: umin_q <= cfg_data_i;
          dpfd_pkg::REG_DRIVE_MAX: umax_q <= cfg_data_i;
          default: ;
        endcase
      end

      // Advance the error and drive histories
      if (push) begin
        e2_q <= e1_q;
        e1_q <= e0_q;
        u2_q <= u1_q;
        u1_q <= u_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      e0_q  <= sat32(sx64(setpoint_i) - sx64(measured_i));
      acc_q <= ACC_W'(-sx64(u2_q));
    end
    if ((state_q == ST_MUL_WAIT) && mul_sts.done) begin
      case (step_q)
        STEP_NT:   nt_q   <= sat32(prod_sh);
        STEP_KDN:  kdn_q  <= sat32(prod_sh);
        STEP_KITA: kita_q <= sat32(prod_sh);
        STEP_P1:   p1_q   <= sat32(prod_sh);
        STEP_P2:   p2_q   <= sat32(prod_sh);
        STEP_P3:   p3_q   <= sat32(prod_sh);
        default:   acc_q  <= acc_q + prod_sh[ACC_W-1:0];
      endcase
    end
    if (div_start) begin
      neg_q <= sum_neg;
    end
    if ((state_q == ST_DIV_WAIT) && div_sts.done) begin
      u_q <= u_clamp;
    end
    if (push) begin
      drive_q <= u_q;
    end
  end

  dpfd_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .op_a_i  (op_a),
    .op_b_i  (op_b),
    .prod_o  (mul_prod),
    .sts_o   (mul_sts)
  );

  dpfd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (one_nt),
    .quotient_o (div_quo),
    .sts_o      (div_sts)
  );

endmodule

>>> rtl/dpfd_checker.sv
// ----------------------------------------------------------------------------
// dpfd_checker
// Port-level checks of the PID block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpfd_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [dpfd_pkg::DATA_W-1:0]        drive_o
);

  // An accepted item keeps the input side closed while it is worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after an item was accepted");

  // A result never appears right after an item was taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !$rose(out_valid_o))
    else $error("result appeared one cycle after acceptance");

  // A new result comes out of busy work and leaves the block idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(in_stall_o) && !in_stall_o))
    else $error("result not tied to the end of an item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(drive_o)))
    else $error("stalled result dropped or changed");

endmodule

bind discrete_pid_filtered_derivative dpfd_checker u_dpfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .drive_o     (drive_o)
);
